### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the alignment score rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AGAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AGAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/agas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agas_pkg
// types, sizes and codes for the affine gap global alignment score block
// ----------------------------------------------------------------------------
package agas_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_COLUMNS = 8192;

    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);

    localparam int SCORE_W   = 32;
    localparam int PARAM_W   = 8;
    localparam int RES_W     = 3;
    localparam int FUNC_W    = 2;
    localparam int APB_DW    = 32;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_START  = 2'd0,
        FN_APPEND = 2'd1,
        FN_COLUMN = 2'd2,
        FN_FINISH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_GAP_OPEN      = 2'd0,
        REG_GAP_EXTENSION = 2'd1,
        REG_MATCH         = 2'd2,
        REG_MISMATCH      = 2'd3
    } cfg_idx_t;

    localparam logic signed [PARAM_W-1:0] GAP_OPEN_RST      = -8'sd11;
    localparam logic signed [PARAM_W-1:0] GAP_EXTENSION_RST = -8'sd1;
    localparam logic signed [PARAM_W-1:0] MATCH_RST         = 8'sd6;
    localparam logic signed [PARAM_W-1:0] MISMATCH_RST      = -8'sd4;

    // one stored row: residue, best score and horizontal gap score
    typedef struct packed {
        logic [RES_W-1:0]          residue;
        logic signed [SCORE_W-1:0] best;
        logic signed [SCORE_W-1:0] horiz;
    } row_entry_t;

    function automatic logic signed [SCORE_W-1:0] sext_param(
        input logic signed [PARAM_W-1:0] v
    );
        return {{(SCORE_W-PARAM_W){v[PARAM_W-1]}}, v};
    endfunction

    function automatic logic signed [SCORE_W-1:0] smax(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

endpackage

### design/affine_gap_global_alignment_score.sv
`timescale 1ns / 1ps
// finish: a finish result sits in the output register from the next cycle
// column item: the read of row zero, then one stored row per cycle through the row memory
// read/modify/write loop; every other item kind is taken one per cycle while no sweep runs,
// a finish item only while the output register is free or leaving
// reset: control state, counters, flag and score registers clear, gap and match registers load
// their defaults; the row memory is not cleared, every row is written by an append before use
// ----------------------------------------------------------------------------
// affine_gap_global_alignment_score
// global alignment score of two dna5 sequences with affine gap penalties
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_gap_global_alignment_score (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [agas_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [agas_pkg::APB_DW-1:0]       pwdata,
    output logic [agas_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [agas_pkg::FUNC_W-1:0]       func,
    input  logic [agas_pkg::RES_W-1:0]        residue,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [agas_pkg::SCORE_W-1:0] score,
    output logic                              too_long
);
    import agas_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_COL
    } state_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [ROW_CNT_W-1:0]       row_cnt_reg, row_cnt_next;
    logic [COL_CNT_W-1:0]       col_cnt_reg, col_cnt_next;
    logic                       limit_reg, limit_next;
    logic [ROW_IDX_W-1:0]       idx_reg, idx_next;
    logic signed [SCORE_W-1:0]  top_reg, top_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SCORE_W-1:0]  score_reg, score_next;
    logic                       too_long_reg, too_long_next;

    logic signed [PARAM_W-1:0]  gap_open_reg, gap_open_next;
    logic signed [PARAM_W-1:0]  gap_ext_reg, gap_ext_next;
    logic signed [PARAM_W-1:0]  match_reg, match_next;
    logic signed [PARAM_W-1:0]  mismatch_reg, mismatch_next;

    // datapath registers, no reset needed
    logic signed [SCORE_W-1:0]  bottom_reg, bottom_next;   // best score of the last row
    logic signed [SCORE_W-1:0]  diag_reg, diag_next;
    logic signed [SCORE_W-1:0]  vert_reg, vert_next;
    logic [RES_W-1:0]           res_reg, res_next;

    // ------------------------------------------------------------------
    // row memory: one entry per stored row, single write, single read
    // ------------------------------------------------------------------
    row_entry_t                 row_mem [MAX_ROWS];
    row_entry_t                 mem_q_reg;
    logic                       mem_we;
    logic [ROW_IDX_W-1:0]       mem_wa;
    row_entry_t                 mem_wd;
    logic [ROW_IDX_W-1:0]       mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= row_mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic in_accept;
    logic cfg_write;
    logic out_free;
    func_t in_func;

    assign in_func   = func_t'(func);
    // a finish item needs the output register free, or leaving this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (!out_free && (in_func == FN_FINISH));
    assign in_accept = in_valid && !in_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign too_long  = too_long_reg;

    // register read back, sign extended
    always_comb
    begin
        case (cfg_idx_t'(paddr[CFG_ADDR_W-1:2]))
            REG_GAP_OPEN:      prdata = APB_DW'(sext_param(gap_open_reg));
            REG_GAP_EXTENSION: prdata = APB_DW'(sext_param(gap_ext_reg));
            REG_MATCH:         prdata = APB_DW'(sext_param(match_reg));
            REG_MISMATCH:      prdata = APB_DW'(sext_param(mismatch_reg));
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // first-column scores: open + extension * index
    // ------------------------------------------------------------------
    logic signed [PARAM_W+COL_CNT_W:0] col_prod;
    logic signed [PARAM_W+ROW_CNT_W:0] row_prod;
    logic signed [SCORE_W-1:0]         col_top;
    logic signed [SCORE_W-1:0]         row_first;

    assign col_prod  = gap_ext_reg * $signed({1'b0, col_cnt_reg});
    assign row_prod  = gap_ext_reg * $signed({1'b0, row_cnt_reg});
    assign col_top   = sext_param(gap_open_reg) + SCORE_W'(col_prod);
    assign row_first = sext_param(gap_open_reg) + SCORE_W'(row_prod);

    // ------------------------------------------------------------------
    // one cell of the gotoh recurrence, on the entry read last cycle
    // ------------------------------------------------------------------
    logic signed [SCORE_W-1:0] subst;
    logic signed [SCORE_W-1:0] cell_best;
    logic signed [SCORE_W-1:0] cell_gap;
    logic signed [SCORE_W-1:0] cell_vert;
    logic signed [SCORE_W-1:0] cell_horiz;
    logic                      last_row;

    always_comb
    begin
        subst      = (res_reg == mem_q_reg.residue) ? sext_param(match_reg)
                                                    : sext_param(mismatch_reg);
        cell_best  = smax(smax(diag_reg + subst, vert_reg), mem_q_reg.horiz);
        cell_gap   = cell_best + sext_param(gap_open_reg);
        cell_vert  = smax(vert_reg + sext_param(gap_ext_reg), cell_gap);
        cell_horiz = smax(mem_q_reg.horiz + sext_param(gap_ext_reg), cell_gap);
    end

    assign last_row = (ROW_CNT_W'(idx_reg) + ROW_CNT_W'(1)) == row_cnt_reg;

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        limit_next     = limit_reg;
        idx_next       = idx_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && out_stall;
        gap_open_next  = gap_open_reg;
        gap_ext_next   = gap_ext_reg;
        match_next     = match_reg;
        mismatch_next  = mismatch_reg;
        bottom_next    = bottom_reg;
        diag_next      = diag_reg;
        vert_next      = vert_reg;
        res_next       = res_reg;
        score_next     = score_reg;
        too_long_next  = too_long_reg;
        mem_we         = 1'b0;
        mem_wa         = row_cnt_reg[ROW_IDX_W-1:0];
        mem_wd         = '{residue: residue, best: row_first,
                           horiz: row_first + sext_param(gap_open_reg)};
        mem_ra         = '0;

        if (cfg_write)
        begin
            case (cfg_idx_t'(paddr[CFG_ADDR_W-1:2]))
                REG_GAP_OPEN:      gap_open_next = pwdata[PARAM_W-1:0];
                REG_GAP_EXTENSION: gap_ext_next  = pwdata[PARAM_W-1:0];
                REG_MATCH:         match_next    = pwdata[PARAM_W-1:0];
                REG_MISMATCH:      mismatch_next = pwdata[PARAM_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_func)
                        FN_START:
                        begin
                            top_next     = '0;
                            row_cnt_next = '0;
                            col_cnt_next = '0;
                            limit_next   = 1'b0;
                        end
                        FN_APPEND:
                        begin
                            if (row_cnt_reg >= ROW_CNT_W'(MAX_ROWS))
                            begin
                                limit_next = 1'b1;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                bottom_next  = row_first;
                                row_cnt_next = row_cnt_reg + ROW_CNT_W'(1);
                            end
                        end
                        FN_COLUMN:
                        begin
                            if (col_cnt_reg >= COL_CNT_W'(MAX_COLUMNS))
                            begin
                                limit_next = 1'b1;
                            end
                            else
                            begin
                                // old top score is the diagonal of row zero
                                diag_next    = top_reg;
                                top_next     = col_top;
                                vert_next    = col_top + sext_param(gap_open_reg);
                                res_next     = residue;
                                idx_next     = '0;
                                col_cnt_next = col_cnt_reg + COL_CNT_W'(1);
                                if (row_cnt_reg != '0)
                                begin
                                    state_next = ST_COL;
                                end
                            end
                        end
                        FN_FINISH:
                        begin
                            out_valid_next = 1'b1;
                            score_next     = (row_cnt_reg != '0) ? bottom_reg : top_reg;
                            too_long_next  = limit_reg;
                        end
                        default: ;
                    endcase
                end
            end
            ST_COL:
            begin
                // write back the cell and fetch the next row
                mem_we    = 1'b1;
                mem_wa    = idx_reg;
                mem_wd    = '{residue: mem_q_reg.residue, best: cell_best, horiz: cell_horiz};
                mem_ra    = idx_reg + ROW_IDX_W'(1);
                diag_next = mem_q_reg.best;
                vert_next = cell_vert;
                idx_next  = idx_reg + ROW_IDX_W'(1);
                if (last_row)
                begin
                    bottom_next = cell_best;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            limit_reg     <= 1'b0;
            idx_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            score_reg     <= '0;
            too_long_reg  <= 1'b0;
            gap_open_reg  <= GAP_OPEN_RST;
            gap_ext_reg   <= GAP_EXTENSION_RST;
            match_reg     <= MATCH_RST;
            mismatch_reg  <= MISMATCH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            limit_reg     <= limit_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            score_reg     <= score_next;
            too_long_reg  <= too_long_next;
            gap_open_reg  <= gap_open_next;
            gap_ext_reg   <= gap_ext_next;
            match_reg     <= match_next;
            mismatch_reg  <= mismatch_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bottom_reg   <= bottom_next;
        diag_reg     <= diag_next;
        vert_reg     <= vert_next;
        res_reg      <= res_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `AGAS_ASSERT(a_busy_stalls, (state_reg != ST_COL) || in_stall, "item taken during column sweep")
    `AGAS_ASSERT(a_idx_in_range, (state_reg != ST_COL) || (ROW_CNT_W'(idx_reg) < row_cnt_reg), "sweep index past stored rows")
    `AGAS_ASSERT(a_counts_bounded, (row_cnt_reg <= ROW_CNT_W'(MAX_ROWS)) && (col_cnt_reg <= COL_CNT_W'(MAX_COLUMNS)), "row or column count beyond limit")
    `AGAS_ASSERT_NEXT(a_column_sweeps, in_accept && (in_func == FN_COLUMN) && (col_cnt_reg < COL_CNT_W'(MAX_COLUMNS)) && (row_cnt_reg != '0), state_reg == ST_COL, "column item did not start a sweep")

endmodule
